### src/sha1h_pkg.sv
// Shared types and constants for the SHA-1 message hasher.
`timescale 1ns / 1ps
package sha1h_pkg;

    // Initial chaining words
    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
    localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K_GRP0 = 32'h5A827999;
    localparam logic [31:0] K_GRP1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_GRP2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_GRP3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_AT    = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam int         ROUNDS    = 80;
    localparam int         ROUND_W   = 7;
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
    localparam logic [ROUND_W-1:0] GRP1_START = 7'd20;
    localparam logic [ROUND_W-1:0] GRP2_START = 7'd40;
    localparam logic [ROUND_W-1:0] GRP3_START = 7'd60;

    // Source of the byte shifted into the block buffer
    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } t_sel;

    // Controller to datapath
    typedef struct packed {
        logic               shift_en;
        t_sel               sel;
        logic               load_work;
        logic               round_en;
        logic [ROUND_W-1:0] round;
        logic               add_en;
        logic               out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [5:0] pos;
        logic       out_full;
    } t_sts;

endpackage

### src/sha1h_ctrl.sv
// Sequencer for byte intake, padding, compression rounds and digest hand-off.
`timescale 1ns / 1ps
module sha1h_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    input  logic             i_s_axis_tuser,
    input  logic             i_s_axis_tlast,
    output logic             o_s_axis_tready,
    input  sha1h_pkg::t_sts  i_sts,
    output sha1h_pkg::t_cmd  o_cmd
);
    import sha1h_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_FILL,
        ST_ROUND,
        ST_ADD,
        ST_DONE
    } t_state;

    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    logic               r_len_ok, n_len_ok;
    logic [ROUND_W-1:0] r_round, n_round;
    logic               accept;
    logic               blk_end;

    assign accept  = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign blk_end = (i_sts.pos == LAST_POS);
    assign o_s_axis_tready = (r_state == ST_IDLE);

    // Next state and command decode
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_len_ok = r_len_ok;
        n_round  = r_round;
        o_cmd           = '0;
        o_cmd.sel       = SEL_ZERO;
        o_cmd.round     = r_round;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_s_axis_tuser) begin
                        o_cmd.shift_en = 1'b1;
                        o_cmd.sel      = SEL_DATA;
                    end
                    if (i_s_axis_tuser && blk_end) begin
                        o_cmd.load_work = 1'b1;
                        n_state = ST_ROUND;
                        n_ret   = i_s_axis_tlast ? ST_MARK : ST_IDLE;
                    end else if (i_s_axis_tlast) begin
                        n_state = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                o_cmd.shift_en = 1'b1;
                o_cmd.sel      = SEL_MARK;
                if (blk_end) begin
                    o_cmd.load_work = 1'b1;
                    n_len_ok = 1'b1;
                    n_ret    = ST_FILL;
                    n_state  = ST_ROUND;
                end else begin
                    // length fits here only if the marker lands at or before byte 55
                    n_len_ok = (i_sts.pos < LEN_AT);
                    n_state  = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.shift_en = 1'b1;
                o_cmd.sel = (r_len_ok && (i_sts.pos >= LEN_AT)) ? SEL_LEN : SEL_ZERO;
                if (blk_end) begin
                    o_cmd.load_work = 1'b1;
                    n_ret    = r_len_ok ? ST_DONE : ST_FILL;
                    n_len_ok = 1'b1;
                    n_state  = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_round = '0;
                    n_state = ST_ADD;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            ST_ADD: begin
                o_cmd.add_en = 1'b1;
                n_state = r_ret;
            end
            ST_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_len_ok <= 1'b0;
            r_round  <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_len_ok <= n_len_ok;
            r_round  <= n_round;
        end
    end

endmodule

### src/sha1h_datapath.sv
// Block window, message schedule, round unit, chaining words and digest register.
`timescale 1ns / 1ps
module sha1h_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_data_byte,
    input  sha1h_pkg::t_cmd  i_cmd,
    output sha1h_pkg::t_sts  o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [159:0]     o_out_data
);
    import sha1h_pkg::*;

    logic [511:0]  r_blk;
    logic [31:0]   r_a, r_b, r_c, r_d, r_e;
    logic [31:0]   r_h [5];
    logic [5:0]    r_pos;
    logic [63:0]   r_bits;
    logic          r_out_valid;
    logic [159:0]  r_out_data;

    logic [7:0]    byte_in;
    logic [7:0]    len_byte;
    logic [31:0]   w_cur, w_new;
    logic [31:0]   f_val, k_val, t_val;

    // Length byte for buffer positions 56..63, most significant first
    assign len_byte = r_bits[{~r_pos[2:0], 3'b000} +: 8];

    always_comb begin
        case (i_cmd.sel)
            SEL_DATA: byte_in = i_data_byte;
            SEL_MARK: byte_in = PAD_MARK;
            SEL_LEN:  byte_in = len_byte;
            default:  byte_in = '0;
        endcase
    end

    // Schedule: window holds w[t..t+15], word 0 in the top bits
    assign w_cur = r_blk[511:480];
    assign w_new = {r_blk[511-13*32-:32] ^ r_blk[511-8*32-:32] ^ r_blk[511-2*32-:32] ^ w_cur}
                   <<< 0;

    // Round function and constant by round group
    always_comb begin
        if (i_cmd.round < GRP1_START) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_GRP0;
        end else if (i_cmd.round < GRP2_START) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_GRP1;
        end else if (i_cmd.round < GRP3_START) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_GRP2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_GRP3;
        end
    end

    assign t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + w_cur;

    // Block window: byte shifts on intake and padding, word shifts during rounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en) begin
            r_blk <= {r_blk[503:0], byte_in};
        end else if (i_cmd.round_en) begin
            r_blk <= {r_blk[479:0], w_new[30:0], w_new[31]};
        end
    end

    // Working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round_en) begin
            r_a <= t_val;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    // Chaining words, byte position and message bit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0] <= H_INIT0;
            r_h[1] <= H_INIT1;
            r_h[2] <= H_INIT2;
            r_h[3] <= H_INIT3;
            r_h[4] <= H_INIT4;
            r_pos  <= '0;
            r_bits <= '0;
        end else begin
            if (i_cmd.add_en) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end else if (i_cmd.out_load) begin
                r_h[0] <= H_INIT0;
                r_h[1] <= H_INIT1;
                r_h[2] <= H_INIT2;
                r_h[3] <= H_INIT3;
                r_h[4] <= H_INIT4;
            end
            if (i_cmd.shift_en) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_bits <= '0;
            end else if (i_cmd.shift_en && (i_cmd.sel == SEL_DATA)) begin
                r_bits <= r_bits + 64'd8;
            end
        end
    end

    // Digest output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_h[4], r_h[3], r_h[2], r_h[1], r_h[0]};
        end
    end

    assign o_sts.pos      = r_pos;
    assign o_sts.out_full = r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

### src/sha1_message_hasher_core.sv
// SHA-1 message hasher: top level joining controller and datapath.
// Rate: one message byte per cycle while the 64-byte block fills; the 64th byte
// starts 80 rounds and the chaining add, during which intake is held off, as the
// one shared round unit does every round of every block.
// Last item to digest: the rest of the block is padded and compressed as the final
// block; a marker past byte 55 adds a second padded block; then the digest loads.
// Reset (synchronous, active low) restores the initial chaining words and clears counts.
`timescale 1ns / 1ps
module sha1_message_hasher_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tuser,   // [0] has_byte
    input  logic         i_s_axis_tlast,   // is_last
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [159:0] o_m_axis_tdata    // digest_word0..digest_word4, 32 bits each
);
    import sha1h_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sha1h_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    sha1h_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

### src/sha1h_checker.sv
// Port-level checks on the SHA-1 hasher, bound to the top level.
`timescale 1ns / 1ps
module sha1h_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         i_s_axis_tlast,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [159:0] o_m_axis_tdata
);

    // A last item always starts padding, so intake stops right after it
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("intake still open after a last item");

    // Digest cannot appear the cycle after a last item: rounds still to run
    a_no_instant_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !$rose(o_m_axis_tvalid))
        else $error("digest appeared without compression");

    // A waiting digest stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("digest dropped or changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("digest valid after reset");

endmodule

bind sha1_message_hasher_core sha1h_checker u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

### dv/testbench.sv
// Self-checking testbench for the SHA-1 message hasher core.
`timescale 1ns / 1ps
module testbench;
    import sha1h_pkg::*;

    localparam int STALL_LIMIT = 5000;  // cycles with no item moved on either side
    localparam int TAIL_CYCLES = 400;   // two padding blocks plus a long output stall
    localparam int ITEM_TARGET = 800;
    localparam int MSG_TARGET  = 40;

    // One pending input item; hold makes the sender wait for all digests first
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
        logic       hold;
    } t_byte_item;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata = '0;   // [7:0] data_byte
    logic         i_s_axis_tuser = 1'b0; // [0] has_byte
    logic         i_s_axis_tlast = 1'b0; // is_last
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [159:0] o_m_axis_tdata;        // digest_word0..digest_word4 from bit 0 up

    t_byte_item   feed_q[$];
    logic [159:0] digest_q[$];

    // Hash state mirror
    logic [31:0]  hash_state [5];
    logic [7:0]   blk_bytes [64];
    int unsigned  fill_pos;
    logic [63:0]  msg_bits;

    int presented_cnt = 0;
    int accepted_cnt = 0;
    int in_gap = 0;
    int in_burst = 0;
    int out_gap = 0;
    int out_burst = 0;
    int stall_cycles = 0;
    int mismatches = 0;
    int digests_checked = 0;
    int msgs_hashed = 0;
    int bytes_hashed = 0;

    sha1_message_hasher_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Predictor: restart for a new message
    function automatic void hash_restart();
        hash_state[0] = H_INIT0;
        hash_state[1] = H_INIT1;
        hash_state[2] = H_INIT2;
        hash_state[3] = H_INIT3;
        hash_state[4] = H_INIT4;
        fill_pos = 0;
        msg_bits = '0;
    endfunction

    // Predictor: 80-round compression of the buffered block
    function automatic void hash_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        for (int r = 0; r < 16; r++)
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
        for (int r = 16; r < 80; r++) begin
            x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {x[30:0], x[31]};
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
        d = hash_state[3]; e = hash_state[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);          k = K_GRP0;
            end else if (r < 40) begin
                f = b ^ c ^ d;                   k = K_GRP1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d); k = K_GRP2;
            end else begin
                f = b ^ c ^ d;                   k = K_GRP3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
        hash_state[3] += d; hash_state[4] += e;
    endfunction

    // Predictor: take one accepted item, queue a digest when it ends a message
    function automatic void hash_item(logic [7:0] data, logic has_byte, logic last);
        logic [159:0] dig;
        if (has_byte) begin
            bytes_hashed++;
            blk_bytes[fill_pos] = data;
            fill_pos++;
            if (fill_pos == 64) begin
                hash_compress();
                msg_bits += 64'd512;
                fill_pos = 0;
            end
        end
        if (last) begin
            msg_bits += 64'(fill_pos * 8);
            blk_bytes[fill_pos] = PAD_MARK;
            fill_pos++;
            // no room for the length: close this block and pad a second one
            if (fill_pos > LEN_AT) begin
                while (fill_pos < 64) begin
                    blk_bytes[fill_pos] = 8'h00;
                    fill_pos++;
                end
                hash_compress();
                fill_pos = 0;
            end
            while (fill_pos < LEN_AT) begin
                blk_bytes[fill_pos] = 8'h00;
                fill_pos++;
            end
            for (int i = 0; i < 8; i++)
                blk_bytes[LEN_AT + i] = msg_bits[8*(7-i) +: 8];
            hash_compress();
            for (int i = 0; i < 5; i++)
                dig[32*i +: 32] = hash_state[i];
            digest_q.push_back(dig);
            msgs_hashed++;
            hash_restart();
        end
    endfunction

    // Idle length: mostly short, a few long, and stretches of none
    function automatic int next_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            burst = $urandom_range(30, 120);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %08h, got %08h", what, exp_v, act_v);
    endtask

    task automatic push_item(logic [7:0] data, logic has_byte, logic last, logic hold);
        t_byte_item it;
        it.data = data;
        it.has_byte = has_byte;
        it.last = last;
        it.hold = hold;
        feed_q.push_back(it);
    endtask

    // Random message; the end comes on the final byte or on a byteless item
    task automatic add_message(int len, bit end_on_byte, bit hold);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_item(8'($urandom()), 1'b0, 1'b0, 1'b0);
            push_item(8'($urandom()), 1'b1, (end_on_byte && i == len - 1), (hold && i == 0));
        end
        if (len == 0 || !end_on_byte)
            push_item(8'($urandom()), 1'b0, 1'b1, (hold && len == 0));
    endtask

    // Stimulus and end of run
    initial begin : stimulus
        int n_items;
        int len;
        int pick;
        int edge_lens [8];
        hash_restart();
        edge_lens = '{55, 56, 57, 63, 64, 65, 119, 128};

        // directed: empty message, "abc", single extreme bytes, ignored items
        push_item(8'hC3, 1'b0, 1'b1, 1'b0);
        push_item(8'hA5, 1'b0, 1'b0, 1'b0);
        push_item(8'h61, 1'b1, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0, 1'b0);
        push_item(8'h63, 1'b1, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0, 1'b0);
        push_item(8'h5A, 1'b0, 1'b1, 1'b0);
        push_item(8'h3C, 1'b0, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b1, 1'b0);

        // padding boundaries, both ways of ending
        n_items = 0;
        for (int i = 0; i < 6; i++) begin
            len = (i < 2) ? 55 : (i < 4) ? 56 : 64;
            add_message(len, i[0], (i == 0));
            n_items += len + 1;
        end

        // random messages until enough items and digests
        for (int m = 0; n_items < ITEM_TARGET || m < MSG_TARGET; m++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                len = $urandom_range(0, 16);
            else if (pick < 85)
                len = edge_lens[$urandom_range(0, 7)];
            else
                len = $urandom_range(0, 130);
            add_message(len, 1'($urandom_range(0, 1)), ($urandom_range(0, 9) == 0));
            n_items += len + 1;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || accepted_cnt != presented_cnt || digest_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d messages (%0d bytes, %0d input items) incl. empty ones",
                 msgs_hashed, bytes_hashed, accepted_cnt);
        $display("and padding edges; %0d digests compared, %0d mismatches.",
                 digests_checked, mismatches);
        if (mismatches == 0 && digest_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Input driver
    always @(negedge i_clk) begin : drive_items
        t_byte_item nxt;
        if (i_rst_n && (!i_s_axis_tvalid || accepted_cnt == presented_cnt)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (feed_q.size() != 0 && !(feed_q[0].hold && digest_q.size() != 0)) begin
                nxt = feed_q.pop_front();
                i_s_axis_tdata <= nxt.data;
                i_s_axis_tuser <= nxt.has_byte;
                i_s_axis_tlast <= nxt.last;
                i_s_axis_tvalid <= 1'b1;
                presented_cnt <= presented_cnt + 1;
                in_gap <= next_gap(in_burst);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(negedge i_clk) begin : drive_ready
        int g;
        if (i_rst_n) begin
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                g = next_gap(out_burst);
                i_m_axis_tready <= (g == 0);
                out_gap <= (g > 0) ? g - 1 : 0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: predict on accepted items, check accepted digests
    always @(posedge i_clk) begin : monitor
        logic [159:0] exp_d;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                hash_item(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (digest_q.size() == 0) begin
                    note_mismatch("unexpected digest, word0", 32'h0, o_m_axis_tdata[31:0]);
                end else begin
                    exp_d = digest_q.pop_front();
                    digests_checked++;
                    for (int i = 0; i < 5; i++)
                        if (o_m_axis_tdata[32*i +: 32] !== exp_d[32*i +: 32])
                            note_mismatch($sformatf("digest %0d word%0d", digests_checked, i),
                                          exp_d[32*i +: 32], o_m_axis_tdata[32*i +: 32]);
                end
            end
        end
    end

    // Watchdog on cycles with no item moved
    always @(posedge i_clk) begin : watchdog
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
